>>> design/signed_log_color_map_core_macros.svh
// Assertion macros used by the color map core.
`ifndef SIGNED_LOG_COLOR_MAP_CORE_MACROS_SVH
`define SIGNED_LOG_COLOR_MAP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SLCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SLCM_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SLCM_ASSERT(label, clk, rst_n, prop)
`define SLCM_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> design/slcm_pkg.sv
`default_nettype none
package slcm_pkg;
    localparam logic [31:0] SCALE_RESET = 32'd65536;
    localparam logic [16:0] Q_ONE       = 17'd65536;
    localparam logic [15:0] Q_POINT7    = 16'd45875;
    localparam logic [15:0] Q_POINT3    = 16'd19661;
    localparam logic [15:0] K_STAGE1    = 16'd27063;
    localparam logic [15:0] K_STAGE2    = 16'd22713;
    localparam logic [15:0] K_STAGE3    = 16'd15142;
    localparam logic [15:0] OUT_MAX     = 16'hFFFF;
    localparam int          DIV_STEPS   = 64;
    localparam int          LOG_BITS    = 16;

    // Work carried through the divider pipeline.
    typedef struct packed {
        logic        neg;
        logic        wzero;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [31:0] div;
    } div_work_t;

    // Work carried through one log2 pipeline.
    typedef struct packed {
        logic [31:0] y;
        logic [15:0] r;
    } log_work_t;

    // One log2 refinement step (one squaring), Q2.30 mantissa.
    function automatic log_work_t log_step(input log_work_t a, input int b);
        log_work_t o;
        logic [63:0] sq;
        o = a;
        sq = ({32'd0, a.y} * {32'd0, a.y}) >> 30;
        if (sq >= 64'h8000_0000)
        begin
            o.y = sq[32:1];
            o.r[b] = 1'b1;
        end
        else
        begin
            o.y = sq[31:0];
        end
        return o;
    endfunction
endpackage
`default_nettype wire

>>> design/slcm_div.sv
`default_nettype none
// Restoring divider: prod / weight, one quotient bit per stage, 64 stages.
module slcm_div
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        en,
    input  wire  logic        in_valid,
    input  wire  logic        in_neg,
    input  wire  logic [63:0] in_prod,
    input  wire  logic [31:0] in_weight,
    output       logic        out_valid,
    output       logic        out_neg,
    output       logic [31:0] out_m
);
    import slcm_pkg::*;

    div_work_t          work_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] vld_reg;
    div_work_t          work_next [DIV_STEPS+1];

    // Stage zero loads the operands.
    always_comb
    begin
        work_next[0].neg   = in_neg;
        work_next[0].wzero = (in_weight == 32'd0);
        work_next[0].rem   = 64'd0;
        work_next[0].quo   = in_prod;
        work_next[0].div   = in_weight;
    end

    // Each stage shifts in one dividend bit and tries a subtract.
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [64:0] sh;
        always_comb
        begin
            sh = {work_reg[i-1].rem, work_reg[i-1].quo[63]};
            work_next[i] = work_reg[i-1];
            work_next[i].quo = {work_reg[i-1].quo[62:0], 1'b0};
            if (sh >= {33'd0, work_reg[i-1].div})
            begin
                work_next[i].rem = 64'(sh - {33'd0, work_reg[i-1].div});
                work_next[i].quo[0] = 1'b1;
            end
            else
            begin
                work_next[i].rem = sh[63:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                work_reg[k] <= (k == 0) ? work_next[0] : work_next[k];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_neg   = work_reg[DIV_STEPS].neg;
    assign out_m     = (work_reg[DIV_STEPS].wzero || work_reg[DIV_STEPS].quo[63:32] != 32'd0)
                       ? 32'hFFFF_FFFF : work_reg[DIV_STEPS].quo[31:0];
endmodule
`default_nettype wire

>>> design/slcm_log.sv
`default_nettype none
// Pipelined log2 of a Q.16 argument >= 1.0, scaled by a Q0.16 constant.
// Stages: normalize, 16 squarings, scale.
module slcm_log
#(
    parameter int SIDE_W = 1
)
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              en,
    input  wire  logic              in_valid,
    input  wire  logic [39:0]       in_x,
    input  wire  logic [15:0]       in_k,
    input  wire  logic [SIDE_W-1:0] in_side,
    output       logic              out_valid,
    output       logic [31:0]       out_s,
    output       logic [SIDE_W-1:0] out_side
);
    import slcm_pkg::*;

    localparam int D = LOG_BITS + 1;

    log_work_t         work_reg [D];
    logic [SIDE_W-1:0] side_reg [D+1];
    logic [D:0]        vld_reg;
    logic [15:0]       k_reg;
    logic [5:0]        p;
    logic [31:0]       y0;
    log_work_t         lw0;

    // Leading one search over the argument.
    always_comb
    begin
        p = 6'd0;
        for (int i = 0; i < 40; i++)
        begin
            if (in_x[i])
            begin
                p = 6'(i);
            end
        end
        if (p >= 6'd30)
        begin
            y0 = 32'(in_x >> (p - 6'd30));
        end
        else
        begin
            y0 = 32'(in_x << (6'd30 - p));
        end
        lw0.y = y0;
        lw0.r = 16'd0;
    end

    // Stage registers: normalize, then one squaring per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg[0] <= lw0;
            side_reg[0] <= in_side;
            for (int j = 1; j < D; j++)
            begin
                work_reg[j] <= log_step(work_reg[j-1], LOG_BITS - j);
                side_reg[j] <= side_reg[j-1];
            end
            side_reg[D] <= side_reg[D-1];
            k_reg       <= in_k;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[D-1:0], in_valid};
        end
    end

    logic [5:0] ip_d_reg [D];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ip_d_reg[0] <= p;
            for (int j = 1; j < D; j++)
            begin
                ip_d_reg[j] <= ip_d_reg[j-1];
            end
        end
    end

    logic [21:0] lg;
    logic [37:0] prod;
    logic [31:0] s_reg;
    assign lg   = (ip_d_reg[D-1] < 6'd16) ? 22'd0 : {6'(ip_d_reg[D-1] - 6'd16), work_reg[D-1].r};
    assign prod = {16'd0, lg} * {22'd0, k_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= 32'(prod >> 16);
        end
    end

    assign out_valid = vld_reg[D];
    assign out_s     = s_reg;
    assign out_side  = side_reg[D];
endmodule
`default_nettype wire

>>> design/signed_log_color_map_core.sv
// Throughput: one item per cycle unless stalled; the 64-stage divider is deepest.
// A stall on the output holds every stage; nothing is lost or repeated.
// Async reset (rst_n low) clears all valid bits; scale <= SCALE_INIT (1.0 default).
`default_nettype none
`include "signed_log_color_map_core_macros.svh"
module signed_log_color_map_core
#(
    parameter logic [31:0] SCALE_INIT = slcm_pkg::SCALE_RESET
)
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        cfg_valid,
    output       logic        cfg_ready,
    input  wire  logic [31:0] cfg_data,
    input  wire  logic        s_axis_tvalid,
    output       logic        s_axis_tready,
    input  wire  logic [63:0] s_axis_tdata,  // value[31:0], weight[63:32]
    output       logic        m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output       logic [47:0] m_axis_tdata   // red[15:0], green[31:16], blue[47:32]
);
    import slcm_pkg::*;

    logic [31:0] scale_reg;
    logic        en;
    logic        in_vld_reg, in_neg_reg;
    logic [31:0] mag_reg, w_reg;
    logic [63:0] prod_reg;
    logic        p_vld_reg, p_neg_reg;
    logic [31:0] pw_reg;

    assign cfg_ready = 1'b1;
    // Whole pipeline advances unless a result waits.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_INIT;
            in_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                scale_reg <= cfg_data;
            end
            if (en)
            begin
                in_vld_reg <= s_axis_tvalid;
                p_vld_reg  <= in_vld_reg;
            end
        end
    end

    // Magnitude, then product with scale.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_neg_reg <= s_axis_tdata[31];
            mag_reg    <= s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0]) : s_axis_tdata[31:0];
            w_reg      <= s_axis_tdata[63:32];
            prod_reg   <= {32'd0, mag_reg} * {32'd0, scale_reg};
            p_neg_reg  <= in_neg_reg;
            pw_reg     <= w_reg;
        end
    end

    logic        d_vld, d_neg;
    logic [31:0] m;
    slcm_div u_div (.clk, .rst_n, .en, .in_valid(p_vld_reg), .in_neg(p_neg_reg),
        .in_prod(prod_reg), .in_weight(pw_reg), .out_valid(d_vld), .out_neg(d_neg),
        .out_m(m));

    // Stage 1: s = log2(100m+1) * K1.
    logic [39:0] x1;
    logic        v1, n1;
    logic [31:0] s1;
    assign x1 = 40'({8'd0, m} * 40'd100) + {23'd0, Q_ONE};
    slcm_log #(.SIDE_W(1)) u_log1 (.clk, .rst_n, .en, .in_valid(d_vld), .in_x(x1),
        .in_k(K_STAGE1), .in_side(d_neg), .out_valid(v1), .out_s(s1), .out_side(n1));

    // Stage 2: s2 = log2(10 max(s-0.7,0)+1) * K2.
    logic [31:0] l1;
    logic [39:0] x2;
    logic        v2, n2;
    logic [31:0] s2, s1d;
    assign l1 = (s1 > {16'd0, Q_POINT7}) ? s1 - {16'd0, Q_POINT7} : 32'd0;
    assign x2 = 40'({8'd0, l1} * 40'd10) + {23'd0, Q_ONE};
    slcm_log #(.SIDE_W(33)) u_log2 (.clk, .rst_n, .en, .in_valid(v1), .in_x(x2),
        .in_k(K_STAGE2), .in_side({n1, s1}), .out_valid(v2), .out_s(s2),
        .out_side({n2, s1d}));

    // Stage 3: s3 = log2(max(s2-0.7,0)+1) * K3.
    logic [31:0] l2;
    logic [39:0] x3;
    logic        v3, n3;
    logic [31:0] s3, s1e, s2e;
    assign l2 = (s2 > {16'd0, Q_POINT7}) ? s2 - {16'd0, Q_POINT7} : 32'd0;
    assign x3 = {8'd0, l2} + {23'd0, Q_ONE};
    slcm_log #(.SIDE_W(65)) u_log3 (.clk, .rst_n, .en, .in_valid(v2), .in_x(x3),
        .in_k(K_STAGE3), .in_side({n2, s1d, s2}), .out_valid(v3), .out_s(s3),
        .out_side({n3, s1e, s2e}));

    // Output: sums to Q4.12 with saturation.
    logic [32:0] warm, mid;
    logic [15:0] ow, om, o3;
    logic        ovld_reg;
    logic [47:0] odata_reg;
    logic        base_ok;
    assign warm = {17'd0, Q_POINT3} + ((s1e > s3) ? {1'b0, s1e - s3} : 33'd0);
    assign mid  = {17'd0, Q_POINT3} + {1'b0, s2e};
    assign ow = (warm[32:4] > 29'(OUT_MAX)) ? OUT_MAX : warm[19:4];
    assign om = (mid[32:4] > 29'(OUT_MAX)) ? OUT_MAX : mid[19:4];
    assign o3 = Q_POINT3[15:4] == 12'd0 ? 16'd0 : {4'd0, Q_POINT3[15:4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            odata_reg <= n3 ? {ow, om, o3} : {o3, om, ow};
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;

    // Either red or blue always carries the fixed 0.3 level.
    assign base_ok = (odata_reg[15:0] == o3) || (odata_reg[47:32] == o3);

    `SLCM_ASSERT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `SLCM_ASSERT(a_ready, clk, rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `SLCM_ASSERT(a_blue, clk, rst_n, m_axis_tvalid |-> base_ok)
endmodule
`default_nettype wire
